[rtl/core/crc8acm_pkg.sv]
`default_nettype none

package crc8acm_pkg;

	localparam logic [7:0] CRC_POLY   = 8'h2F;
	localparam logic [7:0] CRC_INIT   = 8'hFF;
	localparam logic [7:0] CRC_XOROUT = 8'hFF;

	// data-ID byte per alive counter value
	localparam logic [7:0] DATA_ID [16] = '{
		8'h3D, 8'hBE, 8'h44, 8'hC5, 8'h4B, 8'hCC, 8'h52, 8'hD3,
		8'h59, 8'hDA, 8'h60, 8'hE1, 8'h67, 8'hE8, 8'h6E, 8'hEF
	};

	// one message held in the input stage
	typedef struct packed {
		logic [7:0] request_low;
		logic [7:0] request_high;
		logic [7:0] power_first;
		logic [7:0] power_second;
		logic [7:0] reserved_byte;
		logic [3:0] aux_bits;
		logic [3:0] alive_count;
	} msg_t;

	// one result as it leaves the core
	typedef struct packed {
		logic [7:0] comm_byte;
		logic [3:0] alive_count;
		logic [7:0] crc_value;
	} result_t;

	// non-reflected CRC-8 byte step, MSB first
	function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] r;
		r = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			if (r[7]) begin
				r = {r[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				r = {r[6:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/core/crc8acm_crc.sv]
`default_nettype none

// Comm byte and CRC of one message, pure XOR logic.
module crc8acm_crc (
	input  wire crc8acm_pkg::msg_t    msg,
	output crc8acm_pkg::result_t      result
);

	logic [7:0] comm;
	logic [7:0] crc;

	always_comb begin
		comm = {msg.alive_count, msg.aux_bits};
		crc  = crc8acm_pkg::CRC_INIT;
		crc  = crc8acm_pkg::crc_step(crc, msg.request_low);
		crc  = crc8acm_pkg::crc_step(crc, msg.request_high);
		crc  = crc8acm_pkg::crc_step(crc, msg.power_first);
		crc  = crc8acm_pkg::crc_step(crc, msg.power_second);
		crc  = crc8acm_pkg::crc_step(crc, msg.reserved_byte);
		crc  = crc8acm_pkg::crc_step(crc, comm);
		// fold in the data ID, then flush it through one empty byte step
		crc  = crc ^ crc8acm_pkg::DATA_ID[msg.alive_count];
		crc  = crc8acm_pkg::crc_step(crc, 8'h00);

		result.crc_value   = crc ^ crc8acm_pkg::CRC_XOROUT;
		result.alive_count = msg.alive_count;
		result.comm_byte   = comm;
	end

endmodule

`default_nettype wire

[rtl/core/crc8_alive_counter_message_core.sv]
`default_nettype none

// Channel   Dir  Width  Contents (low bit first)
// s_*       in   48     request_low, request_high, power_first, power_second,
//                       reserved_byte, aux_bits, zero pad
// m_*       out  24     crc_value, alive_count, comm_byte, zero pad
//
// One request per cycle sustained while m_tready is high; a result is presented
// once its request has passed the input register, then the result register.
// The alive counter steps at request acceptance, so the first message after
// reset carries 1; arst_n clears the counter and both valid flags.
// A stall on m_tready holds the result register; the input register still takes a
// request while it is empty or while the result register is empty or being drained.
module crc8_alive_counter_message_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [47:0] s_tdata,   // request_low, request_high, power_first,
	                               // power_second, reserved_byte, aux_bits, pad
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata    // crc_value, alive_count, comm_byte, pad
);

	logic                  s_accept;
	logic                  adv_s1;
	logic [3:0]            alive_q;
	logic [3:0]            alive_next;
	logic                  valid_s1;
	crc8acm_pkg::msg_t     msg_s1;
	logic                  valid_s2;
	crc8acm_pkg::result_t  result;
	crc8acm_pkg::result_t  result_s2;

	// move stage 1 into the result register when that register is free or draining
	assign adv_s1     = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready   = !valid_s1 || adv_s1;
	assign s_accept   = s_tvalid && s_tready;
	assign alive_next = alive_q + 4'd1;

	// alive counter: advance once per accepted request, wrap 15 -> 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= '0;
		end else if (s_accept) begin
			alive_q <= alive_next;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			msg_s1.request_low   <= s_tdata[7:0];
			msg_s1.request_high  <= s_tdata[15:8];
			msg_s1.power_first   <= s_tdata[23:16];
			msg_s1.power_second  <= s_tdata[31:24];
			msg_s1.reserved_byte <= s_tdata[39:32];
			msg_s1.aux_bits      <= s_tdata[43:40];
			msg_s1.alive_count   <= alive_next;
		end
	end

	crc8acm_crc u_crc (
		.msg    (msg_s1),
		.result (result)
	);

	// result register: hold while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, result_s2};

endmodule

`default_nettype wire

[rtl/core/crc8acm_chk.sv]
`default_nettype none

module crc8acm_chk (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [23:0] m_tdata
);

	logic       m_accept;
	logic       s_accept;
	logic [3:0] last_alive_q;
	logic [3:0] req_pend_q;

	assign m_accept = m_tvalid && m_tready;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_alive_q <= '0;
		end else if (m_accept) begin
			last_alive_q <= m_tdata[11:8];
		end
	end

	// requests accepted but not yet delivered; never more than the two stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_pend_q <= '0;
		end else begin
			req_pend_q <= req_pend_q + {3'd0, s_accept} - {3'd0, m_accept};
		end
	end

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// delivered counters advance by one, first one is 1
	a_alive_seq: assert property (@(posedge clk) disable iff (!arst_n)
		m_accept |-> m_tdata[11:8] == last_alive_q + 4'd1)
		else $error("alive counter out of sequence");

	// comm byte carries the counter in its upper nibble, pad is zero
	a_comm: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[19:16] == m_tdata[11:8] && m_tdata[23:20] == 4'd0)
		else $error("comm byte does not match alive counter");

	// no result without a request in flight, no more than two in flight
	a_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid |-> req_pend_q != 4'd0) && req_pend_q <= 4'd2)
		else $error("request count in flight out of range");

endmodule

bind crc8_alive_counter_message_core crc8acm_chk u_chk (.*);

`default_nettype wire

[verif/crc8_alive_counter_message_core_test.sv]
`timescale 1ns / 1ps

module crc8_alive_counter_message_core_test;

	// message fields, highest first, so that {pad, msg} lands in s_tdata as the core expects
	typedef struct packed {
		logic [3:0] aux_bits;
		logic [7:0] reserved_byte;
		logic [7:0] power_second;
		logic [7:0] power_first;
		logic [7:0] request_high;
		logic [7:0] request_low;
	} can_msg_t;

	localparam logic [7:0] POLY_2F  = 8'h2F;
	localparam logic [7:0] SEED_FF  = 8'hFF;
	localparam logic [7:0] FINAL_FF = 8'hFF;
	localparam int unsigned DIRECTED_COUNT = 20;
	localparam int unsigned RANDOM_COUNT   = 1800;

	localparam logic [7:0] ID_BY_COUNT [16] = '{
		8'h3D, 8'hBE, 8'h44, 8'hC5, 8'h4B, 8'hCC, 8'h52, 8'hD3,
		8'h59, 8'hDA, 8'h60, 8'hE1, 8'h67, 8'hE8, 8'h6E, 8'hEF
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	wire         s_tready;
	logic [47:0] s_tdata = '0;   // request_low, request_high, power_first,
	                             // power_second, reserved_byte, aux_bits, pad
	wire         m_tvalid;
	logic        m_tready = 1'b0;
	wire  [23:0] m_tdata;        // crc_value, alive_count, comm_byte, pad

	can_msg_t                 outbound_requests [$];
	crc8acm_pkg::result_t     crc_results_due [$];
	can_msg_t                 held_request;
	logic [3:0]               alive_model;
	logic [31:0]              requests_sent;
	logic [31:0]              results_seen;
	int unsigned              send_wait;
	int unsigned              recv_wait;
	int unsigned              stall_draw;
	int unsigned              failures = 0;
	bit                       stimulus_loaded = 1'b0;
	bit                       slot_free;

	crc8_alive_counter_message_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// MSB-first CRC-8 byte update, polynomial 0x2F
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] acc;
		acc = crc ^ data;
		repeat (8) begin
			acc = acc[7] ? ((acc << 1) ^ POLY_2F) : (acc << 1);
		end
		return acc;
	endfunction

	// protected message for one request, given the counter value it carries
	function automatic crc8acm_pkg::result_t crc8_message(input can_msg_t msg,
			input logic [3:0] count);
		crc8acm_pkg::result_t res;
		logic [7:0] comm;
		logic [7:0] crc;
		comm = {count, msg.aux_bits};
		crc = SEED_FF;
		crc = crc8_byte(crc, msg.request_low);
		crc = crc8_byte(crc, msg.request_high);
		crc = crc8_byte(crc, msg.power_first);
		crc = crc8_byte(crc, msg.power_second);
		crc = crc8_byte(crc, msg.reserved_byte);
		crc = crc8_byte(crc, comm);
		crc = crc8_byte(crc ^ ID_BY_COUNT[count], 8'h00);
		res.crc_value   = crc ^ FINAL_FF;
		res.alive_count = count;
		res.comm_byte   = comm;
		return res;
	endfunction

	// every fourth stretch of 32 transfers runs without idling
	function automatic int unsigned idle_cycles(input logic [31:0] seq);
		if (seq[6:5] == 2'b11) begin
			return 0;
		end
		return $urandom_range(0, 6);
	endfunction

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// fill the request queue: directed corners first, then random messages
	initial begin
		can_msg_t m;
		logic [7:0] walk;
		for (int k = 0; k < DIRECTED_COUNT; k++) begin
			walk = 8'h01 << (k % 8);
			case (k)
				0: m = '0;
				1: m = '1;
				2: m = {4'h5, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55};
				3: m = {4'hA, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA};
				4: m = {4'h0, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
				5: m = {4'hF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
				default: begin
					m.request_low   = walk;
					m.request_high  = ~walk;
					m.power_first   = walk;
					m.power_second  = ~walk;
					m.reserved_byte = (k % 2) ? walk : 8'h00;
					m.aux_bits      = 4'(k);
				end
			endcase
			outbound_requests.push_back(m);
		end
		for (int k = 0; k < RANDOM_COUNT; k++) begin
			m.request_low   = rand_byte();
			m.request_high  = rand_byte();
			m.power_first   = rand_byte();
			m.power_second  = rand_byte();
			// reserved is mostly zero, as on a real bus
			m.reserved_byte = ($urandom_range(0, 3) == 0) ? rand_byte() : 8'h00;
			m.aux_bits      = 4'($urandom_range(0, 15));
			outbound_requests.push_back(m);
		end
		stimulus_loaded = 1'b1;
	end

	// request driver: predict on acceptance, then hold off or present the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid      <= 1'b0;
			s_tdata       <= '0;
			send_wait     <= 0;
			alive_model    = 4'd0;
			requests_sent  = '0;
		end else begin
			slot_free = !s_tvalid;
			if (s_tvalid && s_tready) begin
				alive_model = alive_model + 4'd1;
				crc_results_due.push_back(crc8_message(held_request, alive_model));
				requests_sent = requests_sent + 1;
				slot_free = 1'b1;
			end
			if (slot_free) begin
				if (send_wait > 0) begin
					send_wait <= send_wait - 1;
					s_tvalid  <= 1'b0;
				end else if (stimulus_loaded && outbound_requests.size() > 0) begin
					held_request = outbound_requests.pop_front();
					s_tdata   <= {4'h0, held_request};
					s_tvalid  <= 1'b1;
					send_wait <= idle_cycles(requests_sent);
				end else begin
					s_tvalid  <= 1'b0;
				end
			end
		end
	end

	// result monitor: compare each accepted result with the oldest due one
	always @(posedge clk or negedge arst_n) begin
		crc8acm_pkg::result_t got;
		crc8acm_pkg::result_t due;
		if (!arst_n) begin
			m_tready    <= 1'b0;
			recv_wait   <= 0;
			results_seen = '0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[19:0];
				if (crc_results_due.size() == 0) begin
					$error("unexpected result: %h", m_tdata);
					failures++;
				end else begin
					due = crc_results_due.pop_front();
					if (got.crc_value !== due.crc_value) begin
						$error("crc_value: expected %h, actual %h", due.crc_value, got.crc_value);
						failures++;
					end
					if (got.alive_count !== due.alive_count) begin
						$error("alive_count: expected %h, actual %h",
							due.alive_count, got.alive_count);
						failures++;
					end
					if (got.comm_byte !== due.comm_byte) begin
						$error("comm_byte: expected %h, actual %h", due.comm_byte, got.comm_byte);
						failures++;
					end
				end
				results_seen = results_seen + 1;
				stall_draw   = idle_cycles(results_seen);
				recv_wait   <= stall_draw;
				m_tready    <= (stall_draw == 0);
			end else if (recv_wait > 0) begin
				recv_wait <= recv_wait - 1;
				m_tready  <= (recv_wait == 1);
			end else begin
				m_tready  <= 1'b1;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		// wait until every request is accepted, then drain the results
		do @(posedge clk);
		while (!stimulus_loaded || outbound_requests.size() != 0 || s_tvalid);
		while (crc_results_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (failures == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("simulation failed");
		$finish;
	end

endmodule
